FILE: hw/rtl/sccb_pkg.sv
// Shared types and constants for the SCCB line sequencer.
package sccb_pkg;

  // Command codes carried in the mode field of an input beat.
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_SEND  = 3'd3;
  localparam logic [2:0] MODE_RECV  = 3'd4;
  localparam logic [2:0] MODE_ACK   = 3'd5;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitIdxW  = 4;
  localparam logic [UnitW-1:0]   UnitTicksReset = 16'd100;
  localparam logic [BitIdxW-1:0] BitsPerByte    = 4'd8;

  typedef enum logic [13:0] {
    PH_IDLE      = 14'h0001,
    PH_ST1       = 14'h0002,
    PH_ST2       = 14'h0004,
    PH_SP1       = 14'h0008,
    PH_SP2       = 14'h0010,
    PH_TX_HI     = 14'h0020,
    PH_TX_LO     = 14'h0040,
    PH_TX_NEXT   = 14'h0080,
    PH_RX_HI     = 14'h0100,
    PH_RX_SAMPLE = 14'h0200,
    PH_RX_LO     = 14'h0400,
    PH_ACK_HI    = 14'h0800,
    PH_ACK_LO    = 14'h1000,
    PH_ACK_END   = 14'h2000
  } phase_e;

  // Sequencer state carried from one tick to the next.
  typedef struct packed {
    phase_e               phase;
    logic [BitIdxW-1:0]   bit_idx;
    logic [ByteW-1:0]     shift;
    logic [UnitW-1:0]     tick_cnt;
    logic                 unit_left;
    logic                 scl;
    logic                 sda;
    logic                 sda_oe;
  } seq_state_t;

  // Per-tick result flags.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             rejected;
  } seq_flags_t;

endpackage

FILE: hw/rtl/sccb_cmd_if.sv
// Command channel: one tick beat with its command and sampled SDA level.
interface sccb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output mode, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input mode, input tx_byte, input sda_in, output ready);
endinterface

FILE: hw/rtl/sccb_res_if.sv
// Result channel: line levels and status after one tick.
interface sccb_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_oe;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       rejected;

  modport source (output valid, output scl, output sda_out, output sda_oe, output busy_res,
                  output done_res, output rx_byte, output rejected, input ready);
  modport sink   (input valid, input scl, input sda_out, input sda_oe, input busy_res,
                  input done_res, input rx_byte, input rejected, output ready);
endinterface

FILE: hw/rtl/sccb_step.sv
// Next-state logic of the SCCB line sequencer for one tick.
module sccb_step (
  input  sccb_pkg::seq_state_t       state_i,
  input  logic [2:0]                 mode_i,
  input  logic [7:0]                 tx_byte_i,
  input  logic                       sda_in_i,
  input  logic [sccb_pkg::UnitW-1:0] unit_ticks_i,
  output sccb_pkg::seq_state_t       state_o,
  output sccb_pkg::seq_flags_t       flags_o
);
  import sccb_pkg::*;

  logic             is_cmd;
  logic [UnitW-1:0] unit_eff;
  logic [UnitW-1:0] tick_dec;
  logic             wait_set;
  logic             wait_two;
  phase_e           wait_next;
  logic             fin;
  logic             rx_fin;
  logic             act;

  assign is_cmd   = (mode_i >= MODE_START) && (mode_i <= MODE_ACK);
  assign unit_eff = (unit_ticks_i == '0) ? UnitW'(1) : unit_ticks_i;
  assign tick_dec = (state_i.tick_cnt != '0) ? state_i.tick_cnt - UnitW'(1) : state_i.tick_cnt;

  always_comb begin
    state_o   = state_i;
    wait_set  = 1'b0;
    wait_two  = 1'b0;
    wait_next = PH_IDLE;
    fin       = 1'b0;
    rx_fin    = 1'b0;
    act       = 1'b0;
    flags_o.rejected = 1'b0;

    if (state_i.phase == PH_IDLE) begin
      if (is_cmd) begin
        state_o.bit_idx = '0;
        wait_set = 1'b1;
        wait_two = 1'b1;
        case (mode_i)
          MODE_START: begin
            state_o.scl = 1'b1;
            state_o.sda = 1'b1;
            wait_next   = PH_ST1;
          end
          MODE_STOP: begin
            state_o.scl = 1'b0;
            state_o.sda = 1'b0;
            wait_next   = PH_SP1;
          end
          MODE_SEND: begin
            state_o.scl   = 1'b0;
            state_o.sda   = tx_byte_i[ByteW-1];
            state_o.shift = {tx_byte_i[ByteW-2:0], 1'b0};
            wait_next     = PH_TX_HI;
          end
          MODE_RECV: begin
            state_o.sda_oe = 1'b0;
            state_o.scl    = 1'b0;
            state_o.shift  = '0;
            wait_next      = PH_RX_HI;
          end
          default: begin
            state_o.scl = 1'b0;
            state_o.sda = 1'b0;
            wait_next   = PH_ACK_HI;
          end
        endcase
      end
    end else begin
      flags_o.rejected = is_cmd;
      state_o.tick_cnt = tick_dec;
      if (tick_dec == '0) begin
        if (state_i.unit_left) begin
          state_o.unit_left = 1'b0;
          state_o.tick_cnt  = unit_eff;
        end else begin
          act = 1'b1;
        end
      end
    end

    if (act) begin
      unique case (state_i.phase)
        PH_ST1: begin
          state_o.sda = 1'b0;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_ST2;
        end
        PH_ST2: begin
          state_o.scl = 1'b0;
          fin = 1'b1;
        end
        PH_SP1: begin
          state_o.scl = 1'b1;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_SP2;
        end
        PH_SP2: begin
          state_o.sda = 1'b1;
          fin = 1'b1;
        end
        PH_TX_HI: begin
          state_o.scl = 1'b1;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_TX_LO;
        end
        PH_TX_LO: begin
          state_o.scl = 1'b0;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_TX_NEXT;
        end
        PH_TX_NEXT: begin
          state_o.bit_idx = state_i.bit_idx + BitIdxW'(1);
          if (state_o.bit_idx >= BitsPerByte) begin
            fin = 1'b1;
          end else begin
            // drive the next data bit, MSB first
            state_o.sda   = state_i.shift[ByteW-1];
            state_o.shift = {state_i.shift[ByteW-2:0], 1'b0};
            wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_TX_HI;
          end
        end
        PH_RX_HI: begin
          if (state_i.bit_idx >= BitsPerByte) begin
            state_o.sda_oe = 1'b1;
            rx_fin = 1'b1;
            fin    = 1'b1;
          end else begin
            state_o.scl = 1'b1;
            wait_set = 1'b1; wait_next = PH_RX_SAMPLE;
          end
        end
        PH_RX_SAMPLE: begin
          state_o.shift   = {state_i.shift[ByteW-2:0], sda_in_i};
          state_o.bit_idx = state_i.bit_idx + BitIdxW'(1);
          wait_set = 1'b1; wait_next = PH_RX_LO;
        end
        PH_RX_LO: begin
          state_o.scl = 1'b0;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_RX_HI;
        end
        PH_ACK_HI: begin
          state_o.scl = 1'b1;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_ACK_LO;
        end
        PH_ACK_LO: begin
          state_o.scl = 1'b0;
          wait_set = 1'b1; wait_two = 1'b1; wait_next = PH_ACK_END;
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    if (wait_set) begin
      state_o.tick_cnt  = unit_eff;
      state_o.unit_left = wait_two;
      state_o.phase     = wait_next;
    end
    if (fin) begin
      state_o.phase     = PH_IDLE;
      state_o.tick_cnt  = '0;
      state_o.unit_left = 1'b0;
    end

    flags_o.busy    = (state_o.phase != PH_IDLE);
    flags_o.done    = fin;
    flags_o.rx_byte = rx_fin ? state_o.shift : '0;
  end

endmodule

FILE: hw/rtl/sccb_bit_level_master_top.sv
// Top level of the SCCB bit-level master line sequencer.
//
// Every command beat stands for one clock tick of the bus sequencer and
// produces exactly one result beat with the SCL/SDA levels after that tick.
// The block takes one beat per cycle: the whole tick update is combinational
// logic between the sequencer state registers and a result register, and a
// new beat is accepted whenever that result register is empty or being
// drained in the same cycle, so a stalled sink costs nothing until it holds
// one unread result. A start or stop sequence lasts 4 delay units, an ack 6,
// a send 6 units per bit, a receive 4 units per bit plus 2; one unit is
// unit_ticks ticks (0 acts as 1). Commands beats arriving while a sequence
// runs, including on its done tick, are dropped and flagged as rejected.
// Write unit_ticks only while the sequencer is idle; reset value is 100.
module sccb_bit_level_master_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sccb_pkg::UnitW-1:0] cfg_wdata_i,
  sccb_cmd_if.sink                   cmd_i,
  sccb_res_if.source                 res_o
);
  import sccb_pkg::*;

  logic [UnitW-1:0] unit_ticks_q;
  seq_state_t       state_q, state_d;
  seq_flags_t       flags_d;
  logic             res_valid_q;
  logic             cmd_fire;

  // Result payload registers.
  logic             scl_q, sda_q, oe_q;
  seq_flags_t       flags_q;

  // Hold the next beat only when an unread result would be overwritten.
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  sccb_step u_step (
    .state_i      (state_q),
    .mode_i       (cmd_i.mode),
    .tx_byte_i    (cmd_i.tx_byte),
    .sda_in_i     (cmd_i.sda_in),
    .unit_ticks_i (unit_ticks_q),
    .state_o      (state_d),
    .flags_o      (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= UnitTicksReset;
    end else if (cfg_we_i) begin
      unit_ticks_q <= cfg_wdata_i;
    end
  end

  // Advance the sequencer one tick per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_IDLE;
      state_q.bit_idx   <= '0;
      state_q.shift     <= '0;
      state_q.tick_cnt  <= '0;
      state_q.unit_left <= 1'b0;
      state_q.scl       <= 1'b1;
      state_q.sda       <= 1'b1;
      state_q.sda_oe    <= 1'b1;
      res_valid_q       <= 1'b0;
    end else begin
      if (cmd_fire) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      scl_q   <= state_d.scl;
      sda_q   <= state_d.sda;
      oe_q    <= state_d.sda_oe;
      flags_q <= flags_d;
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.scl      = scl_q;
  assign res_o.sda_out  = sda_q;
  assign res_o.sda_oe   = oe_q;
  assign res_o.busy_res = flags_q.busy;
  assign res_o.done_res = flags_q.done;
  assign res_o.rx_byte  = flags_q.rx_byte;
  assign res_o.rejected = flags_q.rejected;

  // A finished sequence leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res)
    else $error("done reported while still busy");

  // Received data appears only on the done beat.
  a_rx_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.rx_byte != '0) |-> res_o.done_res)
    else $error("rx_byte nonzero outside done beat");

  // Idle sequencer carries no pending wait.
  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> (state_q.tick_cnt == '0) && !state_q.unit_left)
    else $error("idle with pending wait");

  // SDA is released only inside a receive sequence.
  a_release_in_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.sda_oe |-> (state_q.phase == PH_RX_HI) || (state_q.phase == PH_RX_SAMPLE) ||
                        (state_q.phase == PH_RX_LO))
    else $error("SDA released outside receive");

endmodule

FILE: tb/sv/tb_sccb_bit_level_master_top.sv
// Self-checking testbench for the SCCB bit-level master line sequencer.
`timescale 1ns / 1ps

module tb_sccb_bit_level_master_top;
  import sccb_pkg::*;

  // Modes 6 and 7 carry no command; the sequencer treats them as plain ticks.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned MAX_REPORTS = 200;
  localparam int unsigned SEG_BEATS   = 50;

  // One command beat: a tick of the sequencer.
  typedef struct packed {
    logic [2:0]       mode;
    logic [ByteW-1:0] tx;
    logic             sda;
  } tick_beat_t;

  // Line levels and status after one tick.
  typedef struct packed {
    logic             scl;
    logic             sda_out;
    logic             sda_oe;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
    logic             rej;
  } line_result_t;

  // Sequencer state mirrored by the predictor.
  typedef struct {
    phase_e             ph;
    logic [BitIdxW-1:0] bit_idx;
    logic [ByteW-1:0]   shift;
    logic [UnitW-1:0]   ticks;
    logic [1:0]         units;
    logic               scl;
    logic               sda;
    logic               oe;
    logic [UnitW-1:0]   unit_ticks;
  } line_model_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [UnitW-1:0] cfg_wdata_i;

  sccb_cmd_if cmd_if ();
  sccb_res_if res_if ();

  sccb_bit_level_master_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  // Free-running clock, 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  tick_beat_t   pending_ticks[$];   // beats waiting for the driver
  line_result_t expected_lines[$]; // predicted results, oldest first
  line_model_t  line_model;        // predictor state, advanced on accepted beats
  line_model_t  gen_model;         // look-ahead copy used to shape stimulus
  tick_beat_t   held_beat;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  mismatches;
  int unsigned  beats_made;
  int unsigned  cycle_cnt;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic line_model_t reset_model();
    line_model_t m;
    m.ph         = PH_IDLE;
    m.bit_idx    = '0;
    m.shift      = '0;
    m.ticks      = '0;
    m.units      = '0;
    m.scl        = 1'b1;
    m.sda        = 1'b1;
    m.oe         = 1'b1;
    m.unit_ticks = UnitTicksReset;
    return m;
  endfunction

  // A unit length of zero counts as one tick.
  function automatic logic [UnitW-1:0] unit_len(input line_model_t m);
    return (m.unit_ticks == '0) ? UnitW'(1) : m.unit_ticks;
  endfunction

  function automatic void arm_wait(inout line_model_t m, input logic [1:0] n,
                                   input phase_e nxt);
    m.ticks = unit_len(m);
    m.units = n - 2'd1;
    m.ph    = nxt;
  endfunction

  // Put the next MSB on SDA and wait two units before raising SCL.
  function automatic void load_bit(inout line_model_t m);
    m.sda   = m.shift[ByteW-1];
    m.shift = {m.shift[ByteW-2:0], 1'b0};
    arm_wait(m, 2'd2, PH_TX_HI);
  endfunction

  // Advance the sequencer by one tick and return the line state after it.
  function automatic line_result_t advance_tick(inout line_model_t m, input tick_beat_t b);
    line_result_t r;
    logic is_cmd;
    logic ended;
    logic rx_valid;
    is_cmd   = (b.mode >= MODE_START) && (b.mode <= MODE_ACK);
    ended    = 1'b0;
    rx_valid = 1'b0;
    r.rej    = 1'b0;
    if (m.ph == PH_IDLE) begin
      if (is_cmd) begin
        m.bit_idx = '0;
        case (b.mode)
          MODE_START: begin
            m.scl = 1'b1;
            m.sda = 1'b1;
            arm_wait(m, 2'd2, PH_ST1);
          end
          MODE_STOP: begin
            m.scl = 1'b0;
            m.sda = 1'b0;
            arm_wait(m, 2'd2, PH_SP1);
          end
          MODE_SEND: begin
            m.scl   = 1'b0;
            m.shift = b.tx;
            load_bit(m);
          end
          MODE_RECV: begin
            m.oe    = 1'b0;
            m.scl   = 1'b0;
            m.shift = '0;
            arm_wait(m, 2'd2, PH_RX_HI);
          end
          default: begin
            m.scl = 1'b0;
            m.sda = 1'b0;
            arm_wait(m, 2'd2, PH_ACK_HI);
          end
        endcase
      end
    end else begin
      // A busy sequencer drops commands, the one on its done tick included.
      r.rej = is_cmd;
      if (m.ticks != '0) m.ticks = m.ticks - UnitW'(1);
      if (m.ticks == '0) begin
        if (m.units != '0) begin
          m.units = m.units - 2'd1;
          m.ticks = unit_len(m);
        end else begin
          case (m.ph)
            PH_ST1: begin
              m.sda = 1'b0;
              arm_wait(m, 2'd2, PH_ST2);
            end
            PH_ST2: begin
              m.scl = 1'b0;
              ended = 1'b1;
            end
            PH_SP1: begin
              m.scl = 1'b1;
              arm_wait(m, 2'd2, PH_SP2);
            end
            PH_SP2: begin
              m.sda = 1'b1;
              ended = 1'b1;
            end
            PH_TX_HI: begin
              m.scl = 1'b1;
              arm_wait(m, 2'd2, PH_TX_LO);
            end
            PH_TX_LO: begin
              m.scl = 1'b0;
              arm_wait(m, 2'd2, PH_TX_NEXT);
            end
            PH_TX_NEXT: begin
              m.bit_idx = m.bit_idx + BitIdxW'(1);
              if (m.bit_idx >= BitsPerByte) ended = 1'b1;
              else load_bit(m);
            end
            PH_RX_HI: begin
              if (m.bit_idx >= BitsPerByte) begin
                m.oe     = 1'b1;
                rx_valid = 1'b1;
                ended    = 1'b1;
              end else begin
                m.scl = 1'b1;
                arm_wait(m, 2'd1, PH_RX_SAMPLE);
              end
            end
            PH_RX_SAMPLE: begin
              // Sample SDA in the middle of the high phase.
              m.shift   = {m.shift[ByteW-2:0], b.sda};
              m.bit_idx = m.bit_idx + BitIdxW'(1);
              arm_wait(m, 2'd1, PH_RX_LO);
            end
            PH_RX_LO: begin
              m.scl = 1'b0;
              arm_wait(m, 2'd2, PH_RX_HI);
            end
            PH_ACK_HI: begin
              m.scl = 1'b1;
              arm_wait(m, 2'd2, PH_ACK_LO);
            end
            PH_ACK_LO: begin
              m.scl = 1'b0;
              arm_wait(m, 2'd2, PH_ACK_END);
            end
            default: ended = 1'b1;
          endcase
        end
      end
    end
    if (ended) begin
      m.ph    = PH_IDLE;
      m.ticks = '0;
      m.units = '0;
    end
    r.scl     = m.scl;
    r.sda_out = m.sda;
    r.sda_oe  = m.oe;
    r.busy    = (m.ph != PH_IDLE);
    r.done    = ended;
    r.rx      = rx_valid ? m.shift : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pop pending beats, hold each until the handshake takes it, and
  // predict the result of every accepted beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_lines.push_back(advance_tick(line_model, held_beat));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_beat = pending_ticks.pop_front();
          cmd_if.valid   <= 1'b1;
          cmd_if.mode    <= held_beat.mode;
          cmd_if.tx_byte <= held_beat.tx;
          cmd_if.sda_in  <= held_beat.sda;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each result beat with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    line_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, expected none actual scl=%0b sda=%0b",
                     $time, res_if.scl, res_if.sda_out);
        end else begin
          want = expected_lines.pop_front();
          compare_field("scl", 8'(want.scl), 8'(res_if.scl));
          compare_field("sda_out", 8'(want.sda_out), 8'(res_if.sda_out));
          compare_field("sda_oe", 8'(want.sda_oe), 8'(res_if.sda_oe));
          compare_field("busy_res", 8'(want.busy), 8'(res_if.busy_res));
          compare_field("done_res", 8'(want.done), 8'(res_if.done_res));
          compare_field("rx_byte", want.rx, res_if.rx_byte);
          compare_field("rejected", 8'(want.rej), 8'(res_if.rejected));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue a beat and advance the look-ahead model with it.
  task automatic push_beat(input tick_beat_t b);
    void'(advance_tick(gen_model, b));
    pending_ticks.push_back(b);
    beats_made++;
  endtask

  // Filler for a running sequence: mostly plain ticks; with noise, also the
  // spare modes and stray commands that the sequencer has to drop.
  function automatic tick_beat_t filler_beat(input bit noisy);
    tick_beat_t b;
    int unsigned r;
    r      = $urandom_range(99);
    b.mode = MODE_TICK;
    b.tx   = ByteW'($urandom_range(255));
    b.sda  = 1'($urandom_range(1));
    if (noisy && r >= 90) b.mode = 3'($urandom_range(MODE_ACK, MODE_START));
    else if (noisy && r >= 80) b.mode = r[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
    return b;
  endfunction

  // Issue a command and tick until the sequence ends. With hit_end, place a
  // stray command on the done tick, where it must still be rejected.
  task automatic run_cmd(input logic [2:0] mode, input logic [ByteW-1:0] tx,
                         input bit noisy, input bit hit_end);
    tick_beat_t   b;
    line_model_t  peek;
    line_result_t peek_res;
    b.mode = mode;
    b.tx   = tx;
    b.sda  = 1'($urandom_range(1));
    push_beat(b);
    while (gen_model.ph != PH_IDLE) begin
      peek     = gen_model;
      b        = filler_beat(1'b0);
      peek_res = advance_tick(peek, b);
      if (hit_end && peek_res.done)
        b.mode = 3'($urandom_range(MODE_ACK, MODE_START));
      else
        b = filler_beat(noisy);
      push_beat(b);
    end
  endtask

  // Push plain ticks until the sequencer is idle again.
  task automatic settle();
    while (gen_model.ph != PH_IDLE) push_beat(filler_beat(1'b0));
  endtask

  // Let everything drain, then switch the idle pattern and rewrite unit_ticks.
  task automatic next_phase(input int unsigned s_pct, input int unsigned r_pct,
                            input logic [UnitW-1:0] unit);
    settle();
    @(negedge clk_i);
    while (pending_ticks.size() > 0 || cmd_if.valid || expected_lines.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    cfg_wdata_i <= unit;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    line_model.unit_ticks = unit;
    gen_model.unit_ticks  = unit;
    @(negedge clk_i);
  endtask

  // Random part: mostly whole commands with random content, some idle ticks.
  task automatic random_segment();
    int unsigned first;
    tick_beat_t  b;
    first = beats_made;
    while (beats_made - first < SEG_BEATS) begin
      if ($urandom_range(99) < 85) begin
        run_cmd(3'($urandom_range(MODE_ACK, MODE_START)), ByteW'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        b = filler_beat(1'b1);
        push_beat(b);
      end
    end
  endtask

  initial begin
    tick_beat_t b;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    cmd_if.valid   = 1'b0;
    cmd_if.mode    = MODE_TICK;
    cmd_if.tx_byte = '0;
    cmd_if.sda_in  = 1'b0;
    res_if.ready   = 1'b0;
    send_idle_pct  = 26;
    recv_idle_pct  = 67;
    mismatches     = 0;
    beats_made     = 0;
    cycle_cnt      = 0;
    line_model     = reset_model();
    gen_model      = reset_model();

    // Hold reset at the start, then release it once.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle ticks in every non-command mode, then a start sequence
    // at the reset unit length with a stray command on its done tick.
    b = '{mode: MODE_TICK, tx: 8'h00, sda: 1'b0};
    push_beat(b);
    b = '{mode: MODE_SPARE_LO, tx: 8'hFF, sda: 1'b1};
    push_beat(b);
    b = '{mode: MODE_SPARE_HI, tx: 8'h00, sda: 1'b0};
    push_beat(b);
    run_cmd(MODE_START, 8'h00, 1'b1, 1'b1);

    // Directed at the shortest real unit: every command, byte extremes.
    next_phase(26, 67, 16'd1);
    run_cmd(MODE_SEND, 8'h00, 1'b0, 1'b0);
    run_cmd(MODE_SEND, 8'hFF, 1'b1, 1'b1);
    run_cmd(MODE_SEND, 8'h96, 1'b0, 1'b1);
    run_cmd(MODE_RECV, 8'h00, 1'b1, 1'b0);
    run_cmd(MODE_RECV, 8'hFF, 1'b0, 1'b1);
    run_cmd(MODE_ACK, 8'h00, 1'b1, 1'b1);
    run_cmd(MODE_STOP, 8'h00, 1'b0, 1'b1);
    b = '{mode: MODE_SPARE_HI, tx: 8'h5A, sda: 1'b1};
    push_beat(b);
    run_cmd(MODE_START, 8'hFF, 1'b1, 1'b0);

    // Directed with a zero unit length, which must act as one tick.
    next_phase(26, 67, 16'd0);
    run_cmd(MODE_START, 8'h00, 1'b0, 1'b1);
    run_cmd(MODE_SEND, 8'hA5, 1'b1, 1'b0);
    run_cmd(MODE_RECV, 8'h00, 1'b1, 1'b1);
    run_cmd(MODE_ACK, 8'h00, 1'b0, 1'b0);
    run_cmd(MODE_STOP, 8'h00, 1'b1, 1'b1);

    // Random: slow sink, then slow source, then no idling; small unit lengths.
    next_phase(26, 67, 16'd2);
    random_segment();
    next_phase(26, 67, UnitW'($urandom_range(3)));
    random_segment();
    next_phase(67, 26, 16'd3);
    random_segment();
    next_phase(67, 26, UnitW'($urandom_range(4)));
    random_segment();
    next_phase(0, 0, 16'd1);
    random_segment();
    next_phase(0, 0, UnitW'($urandom_range(3)));
    random_segment();
    settle();

    // Drain, then let the result register show any stray beats.
    @(negedge clk_i);
    while (pending_ticks.size() > 0 || cmd_if.valid || expected_lines.size() > 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
